FILE: hdl/pcx_rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_pkg
// shared types and constants of the pcx run-length scanline decoder
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

    // run marker: both top bits set, low six bits carry the count
    localparam logic [7:0] RUN_FLAGS      = 8'hC0;
    localparam logic [7:0] RUN_COUNT_MASK = 8'h3F;

    localparam int COUNT_W = 6;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 2;

    // register indexes on the configuration port
    localparam logic [INDEX_W-1:0] REG_BYTES_PER_LINE = 2'd0;
    localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
    localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;

    localparam logic [CFG_W-1:0] RST_BYTES_PER_LINE = 16'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 16'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 16'd480;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]         value;
        logic [COUNT_W-1:0] count;
        logic               start;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] bytes_per_line;
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
    } cfg_t;

endpackage

FILE: hdl/pcx_rle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_front
// accepts compressed bytes, pairs run markers with their value byte
// ----------------------------------------------------------------------------
module pcx_rle_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                image_start,
    output logic                push,
    output pcx_rle_pkg::cmd_t   push_cmd,
    input  logic                queue_full
);

    logic                            marker_reg;
    logic                            marker_next;
    logic [pcx_rle_pkg::COUNT_W-1:0] count_reg;
    logic [pcx_rle_pkg::COUNT_W-1:0] count_next;
    logic                            marker_eff;
    logic [pcx_rle_pkg::COUNT_W-1:0] count_eff;
    logic [7:0]                      masked;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;
    assign masked   = data_byte & pcx_rle_pkg::RUN_COUNT_MASK;

    always_comb
    begin
        marker_eff     = image_start ? 1'b0 : marker_reg;
        count_eff      = image_start ? '0 : count_reg;
        marker_next    = marker_reg;
        count_next     = count_reg;
        push_cmd.value = data_byte;
        push_cmd.start = image_start;
        push_cmd.count = pcx_rle_pkg::COUNT_W'(1);
        if (marker_eff)
        begin
            // value byte of a run
            push_cmd.count = count_eff;
            if (push)
            begin
                marker_next = 1'b0;
                count_next  = '0;
            end
        end
        else if ((data_byte & pcx_rle_pkg::RUN_FLAGS) == pcx_rle_pkg::RUN_FLAGS)
        begin
            // marker only carries the start flag on to the back
            push_cmd.count = '0;
            if (push)
            begin
                marker_next = 1'b1;
                count_next  = masked[pcx_rle_pkg::COUNT_W-1:0];
            end
        end
        else if (push)
        begin
            marker_next = 1'b0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            marker_reg <= marker_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/pcx_rle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_queue
// short command fifo between front and back
// ----------------------------------------------------------------------------
module pcx_rle_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pcx_rle_pkg::cmd_t  push_cmd,
    output logic               full,
    input  logic               pop,
    output pcx_rle_pkg::cmd_t  pop_cmd,
    output logic               empty
);

    localparam logic [pcx_rle_pkg::QPTR_W-1:0] LAST_PTR =
        pcx_rle_pkg::QPTR_W'(pcx_rle_pkg::QUEUE_DEPTH - 1);
    localparam logic [pcx_rle_pkg::QCNT_W-1:0] DEPTH_CNT =
        pcx_rle_pkg::QCNT_W'(pcx_rle_pkg::QUEUE_DEPTH);

    pcx_rle_pkg::cmd_t                entry_reg [pcx_rle_pkg::QUEUE_DEPTH];
    logic [pcx_rle_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [pcx_rle_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [pcx_rle_pkg::QCNT_W-1:0]   cnt_reg;

    assign full    = (cnt_reg == DEPTH_CNT);
    assign empty   = (cnt_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/pcx_rle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_back
// expands commands into pixels, tracks line position, row and end of image
// ----------------------------------------------------------------------------
module pcx_rle_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  pcx_rle_pkg::cfg_t  cfg,
    input  logic               queue_empty,
    input  pcx_rle_pkg::cmd_t  pop_cmd,
    output logic               pop,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         pixel,
    output logic [15:0]        column,
    output logic [15:0]        row,
    output logic               last_of_run
);

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam int W = pcx_rle_pkg::CFG_W;

    state_t                          state_reg,     state_next;
    logic [7:0]                      value_reg,     value_next;
    logic [pcx_rle_pkg::COUNT_W-1:0] remain_reg,    remain_next;
    logic [W-1:0]                    lp_reg,        lp_next;
    logic [W-1:0]                    row_idx_reg,   row_idx_next;
    logic                            fin_reg,       fin_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      pixel_reg,     pixel_next;
    logic [W-1:0]                    column_reg,    column_next;
    logic [W-1:0]                    row_reg,       row_next;
    logic                            last_reg,      last_next;

    logic [W-1:0] bpl_eff;
    logic [W-1:0] height_eff;
    logic [W-1:0] lp_start;
    logic [W-1:0] row_start;
    logic         fin_start;
    logic         out_free;
    logic         visible;
    logic [W:0]   lp_inc;
    logic [W:0]   row_inc;
    logic         line_end;

    assign bpl_eff    = (cfg.bytes_per_line == '0) ? W'(1) : cfg.bytes_per_line;
    assign height_eff = (cfg.image_height == '0) ? W'(1) : cfg.image_height;
    assign out_free   = !out_valid_reg || !out_stall;
    assign visible    = (lp_reg < cfg.image_width);
    assign lp_inc     = {1'b0, lp_reg} + 1'b1;
    assign row_inc    = {1'b0, row_idx_reg} + 1'b1;
    assign line_end   = (lp_inc >= {1'b0, bpl_eff}) || lp_inc[W];

    assign busy        = (state_reg == ST_RUN);
    assign out_valid   = out_valid_reg;
    assign pixel       = pixel_reg;
    assign column      = column_reg;
    assign row         = row_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        remain_next    = remain_reg;
        lp_next        = lp_reg;
        row_idx_next   = row_idx_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        pixel_next     = pixel_reg;
        column_next    = column_reg;
        row_next       = row_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        lp_start       = pop_cmd.start ? '0 : lp_reg;
        row_start      = pop_cmd.start ? '0 : row_idx_reg;
        fin_start      = pop_cmd.start ? 1'b0 : fin_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop          = 1'b1;
                    lp_next      = lp_start;
                    row_idx_next = row_start;
                    fin_next     = fin_start || (row_start >= height_eff);
                    value_next   = pop_cmd.value;
                    remain_next  = pop_cmd.count;
                    if (!fin_next && (pop_cmd.count != '0))
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // hidden columns advance without waiting for the output
                if (!visible || out_free)
                begin
                    if (visible)
                    begin
                        out_valid_next = 1'b1;
                        pixel_next     = value_reg;
                        column_next    = lp_reg;
                        row_next       = row_idx_reg;
                        last_next      = (remain_reg == pcx_rle_pkg::COUNT_W'(1)) || line_end
                                         || (lp_inc >= {1'b0, cfg.image_width});
                    end
                    remain_next = remain_reg - 1'b1;
                    if (line_end)
                    begin
                        // run is cut at the end of the line
                        lp_next      = '0;
                        row_idx_next = row_inc[W-1:0];
                        if ((row_inc >= {1'b0, height_eff}) || row_inc[W])
                        begin
                            fin_next = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        lp_next = lp_inc[W-1:0];
                        if (remain_reg == pcx_rle_pkg::COUNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            lp_reg        <= '0;
            row_idx_reg   <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            lp_reg        <= lp_next;
            row_idx_reg   <= row_idx_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        pixel_reg  <= pixel_next;
        column_reg <= column_next;
        row_reg    <= row_next;
        last_reg   <= last_next;
    end

endmodule

FILE: hdl/pcx_rle_scanline_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder
// run-length decoder for the compressed scanline bytes of a pcx image
// ----------------------------------------------------------------------------
// one compressed byte is taken per input transfer. the front stage pairs each
// run marker with its value byte and writes one command per byte into a
// two-entry queue; the back stage pops a command, then emits one pixel per
// cycle unless out_stall holds the output. a literal byte gives a pop and one
// pixel, a marker or zero-count run a pop only, a run of n bytes a pop and n
// pixels, cut short at a scanline end. columns at or beyond image_width pass
// through the back stage but give no output transfer. the rate is set by the
// single pixel counter of the back stage. last_of_run marks the final pixel
// caused by one input byte. configuration registers are written through
// cfg_we / cfg_index / cfg_data and must only change while the block is idle.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [pcx_rle_pkg::INDEX_W-1:0]     cfg_index,
    input  logic [pcx_rle_pkg::CFG_W-1:0]       cfg_data,
    // compressed byte input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                image_start,
    // pixel output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          pixel,
    output logic [15:0]                         column,
    output logic [15:0]                         row,
    output logic                                last_of_run
);

    // configuration registers
    pcx_rle_pkg::cfg_t cfg_reg;
    pcx_rle_pkg::cfg_t cfg_next;

    // front to queue
    logic              push;
    pcx_rle_pkg::cmd_t push_cmd;
    logic              queue_full;

    // queue to back
    logic              pop;
    pcx_rle_pkg::cmd_t pop_cmd;
    logic              queue_empty;
    logic              back_busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pcx_rle_pkg::REG_BYTES_PER_LINE: cfg_next.bytes_per_line = cfg_data;
                pcx_rle_pkg::REG_IMAGE_WIDTH:    cfg_next.image_width    = cfg_data;
                pcx_rle_pkg::REG_IMAGE_HEIGHT:   cfg_next.image_height   = cfg_data;
                default:                         cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_line <= pcx_rle_pkg::RST_BYTES_PER_LINE;
            cfg_reg.image_width    <= pcx_rle_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height   <= pcx_rle_pkg::RST_IMAGE_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // marker pairing and input transfer
    pcx_rle_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .image_start (image_start),
        .push        (push),
        .push_cmd    (push_cmd),
        .queue_full  (queue_full)
    );

    // lets the front keep accepting while the back expands a run
    pcx_rle_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (queue_empty)
    );

    // run expansion, line and row tracking, registered output
    pcx_rle_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .busy        (back_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel       (pixel),
        .column      (column),
        .row         (row),
        .last_of_run (last_of_run)
    );

    // no write into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("command queue written while full");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty)
        else $error("command queue read while empty");

    // a transfer not marked last must be followed by more pixels of the same byte
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=> (out_valid || back_busy))
        else $error("pixel run ended without last_of_run");

endmodule
